// File: sv/gpio_port_register_block_top_macros.svh
// Assertion macros shared by the GPIO port register block.
`ifndef GPIO_PORT_REGISTER_BLOCK_TOP_MACROS_SVH
`define GPIO_PORT_REGISTER_BLOCK_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define GPR_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gpr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GPR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gpr assertion failed");

`else

`define GPR_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define GPR_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/gpr_pkg.sv
// Package with the types, constants and mode encoder of the GPIO port register block.
`timescale 1ns / 1ps

package gpr_pkg;

    localparam int NUM_PORTS     = 7;
    localparam int PINS_PER_PORT = 16;

    // Width of the pin fields in a word.
    localparam int FIELD_W  = 16;
    // Pins that a port really has; field bits above this are ignored.
    localparam int PIN_SPAN = (PINS_PER_PORT < FIELD_W) ? PINS_PER_PORT : FIELD_W;
    localparam int MODE_W   = 4 * PIN_SPAN;
    localparam int PORT_SEL_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    localparam logic [2:0] OP_ENABLE    = 3'd0;
    localparam logic [2:0] OP_CONFIGURE = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_SET       = 3'd3;
    localparam logic [2:0] OP_CLEAR     = 3'd4;
    localparam logic [2:0] OP_TOGGLE    = 3'd5;
    localparam logic [2:0] OP_READ      = 3'd6;

    localparam logic [2:0] PM_INPUT     = 3'd0;
    localparam logic [2:0] PM_PUSH_PULL = 3'd1;
    localparam logic [2:0] PM_OPEN_DRN  = 3'd2;
    localparam logic [2:0] PM_ANALOG    = 3'd3;
    localparam logic [2:0] PM_ALT_PP    = 3'd4;
    localparam logic [2:0] PM_ALT_OD    = 3'd5;

    localparam logic [3:0] MC_ANALOG    = 4'h0;
    localparam logic [3:0] MC_PUSH_PULL = 4'h3;
    localparam logic [3:0] MC_FLOATING  = 4'h4;
    localparam logic [3:0] MC_OPEN_DRN  = 4'h7;
    localparam logic [3:0] MC_PULLED    = 4'h8;
    localparam logic [3:0] MC_ALT_PP    = 4'hB;
    localparam logic [3:0] MC_ALT_OD    = 4'hF;

    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         port_index;
        logic [FIELD_W-1:0] pin_mask;
        logic [FIELD_W-1:0] level_bits;
        logic [2:0]         pin_mode;
        logic               pull_enable;
        logic [FIELD_W-1:0] pin_levels_in;
    } t_item;

    typedef struct packed {
        logic [FIELD_W-1:0] read_data;
        logic [FIELD_W-1:0] output_levels;
        logic               port_enabled;
    } t_result;

    // Configuration nibble for a pin mode; unknown modes fall back to floating input.
    function automatic logic [3:0] mode_code(input logic [2:0] mode, input logic pull);
        logic [3:0] code;
        case (mode)
            PM_INPUT:     code = pull ? MC_PULLED : MC_FLOATING;
            PM_PUSH_PULL: code = MC_PUSH_PULL;
            PM_OPEN_DRN:  code = MC_OPEN_DRN;
            PM_ANALOG:    code = MC_ANALOG;
            PM_ALT_PP:    code = MC_ALT_PP;
            PM_ALT_OD:    code = MC_ALT_OD;
            default:      code = MC_FLOATING;
        endcase
        return code;
    endfunction

endpackage

// File: sv/gpr_port_file.sv
// Port state registers and the masked read-modify-write of one port per cycle.
`timescale 1ns / 1ps

module gpr_port_file (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  gpr_pkg::t_item   i_item,
    output gpr_pkg::t_result o_result
);
    import gpr_pkg::*;

    logic [NUM_PORTS-1:0] r_enable;
    logic [MODE_W-1:0]    r_mode [NUM_PORTS];
    logic [PIN_SPAN-1:0]  r_out  [NUM_PORTS];

    logic [3:0]            port_ext;
    logic [PORT_SEL_W-1:0] sel;
    logic                  port_ok;
    logic [PIN_SPAN-1:0]   mask;
    logic [PIN_SPAN-1:0]   level;
    logic [PIN_SPAN-1:0]   cur_out;
    logic [PIN_SPAN-1:0]   n_out;
    logic [MODE_W-1:0]     cur_mode;
    logic [MODE_W-1:0]     n_mode;
    logic [3:0]            code;
    logic                  cur_en;

    always_comb begin
        port_ext = {1'b0, i_item.port_index};
        sel      = port_ext[PORT_SEL_W-1:0];
        port_ok  = ({1'b0, port_ext} < 5'(NUM_PORTS));
        mask     = i_item.pin_mask[PIN_SPAN-1:0];
        level    = i_item.level_bits[PIN_SPAN-1:0];
        cur_out  = port_ok ? r_out[sel]  : '0;
        cur_mode = port_ok ? r_mode[sel] : '0;
        cur_en   = port_ok ? r_enable[sel] : 1'b0;
        code     = mode_code(i_item.pin_mode, i_item.pull_enable);

        n_mode = cur_mode;
        for (int i = 0; i < PIN_SPAN; i++) begin
            if (mask[i]) begin
                n_mode[4*i +: 4] = code;
            end
        end

        case (i_item.operation)
            OP_WRITE:  n_out = (cur_out & ~mask) | (level & mask);
            OP_SET:    n_out = cur_out | mask;
            OP_CLEAR:  n_out = cur_out & ~mask;
            OP_TOGGLE: n_out = cur_out ^ mask;
            default:   n_out = cur_out;
        endcase

        o_result.read_data     = (port_ok && i_item.operation == OP_READ)
                               ? FIELD_W'(i_item.pin_levels_in[PIN_SPAN-1:0] & mask) : '0;
        o_result.output_levels = port_ok ? FIELD_W'(n_out) : '0;
        o_result.port_enabled  = port_ok && (cur_en || i_item.operation == OP_ENABLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_mode[p] <= {PIN_SPAN{MC_FLOATING}};
                r_out[p]  <= '0;
            end
        end else if (i_valid && port_ok) begin
            case (i_item.operation)
                OP_ENABLE:    r_enable[sel] <= 1'b1;
                OP_CONFIGURE: r_mode[sel]   <= n_mode;
                OP_WRITE,
                OP_SET,
                OP_CLEAR,
                OP_TOGGLE:    r_out[sel]    <= n_out;
                default:      ;
            endcase
        end
    end

endmodule

// File: sv/gpio_port_register_block_top.sv
// Top level of the GPIO port register block: input register, port file, result register.
`timescale 1ns / 1ps

// The block holds the enable flag, the per-pin mode nibbles and the output
// register of every GPIO port, and carries out one operation on one port per
// word. A word is accepted at every rising edge where start is high and busy
// is low; busy never rises, so a new word may follow in every cycle. Each word
// gives exactly one result: it is first captured in the input register, then
// the masked read-modify-write of the addressed port is done combinationally
// while the result register is loaded. A word that follows directly on the same
// port sees the state that the previous word left, because the port state is
// written at the same edge as the result. The result is shown for exactly one
// cycle with o_done high, and the receiver cannot stall it, so it must take
// every result as it comes. A port index beyond the last port changes nothing
// and returns all zeros.

`include "gpio_port_register_block_top_macros.svh"

module gpio_port_register_block_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  gpr_pkg::t_item   i_item,
    output logic             o_done,
    output gpr_pkg::t_result o_result
);
    import gpr_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_done;
    t_result r_result;
    t_result n_result;
    logic    accept;

    // Every word passes through the input register and the result register, so the block is never busy.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_item;
        end
    end

    gpr_port_file u_port_file (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_item   (r_in_item),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // An accepted word is in the input register in the next cycle.
    `GPR_ASSERT_NEXT(a_accept_to_stage, i_clk, i_rst_n, accept, r_in_valid)
    // A word in the input register always produces a result in the next cycle.
    `GPR_ASSERT_NEXT(a_stage_to_done, i_clk, i_rst_n, r_in_valid, o_done)
    // Every result goes back to an earlier accepted word that passed through the input register.
    `GPR_ASSERT_SAME(a_done_has_word, i_clk, i_rst_n, o_done, $past(accept, 2))
    // Read data can only be nonzero for a read operation.
    `GPR_ASSERT_SAME(a_read_only, i_clk, i_rst_n, o_done && o_result.read_data != '0, $past(r_in_item.operation == OP_READ))

endmodule

// File: test/tb.sv
// Self-checking testbench for the GPIO port register block: directed and random words.
`timescale 1ns / 1ps

// The driver feeds words from a queue to the block, with a random pause
// before each word and calm stretches without pauses. At every accepted word
// the predictor updates its own copy of the port state (enable flags, mode
// nibbles and output registers) and queues the result that the word must give.
// The monitor takes every result the block strobes out and compares it field
// by field with the oldest expected result. The run ends once every word has
// been accepted and every expected result has come back, after a short drain
// that catches stray results.
module tb;
    import gpr_pkg::*;

    // Codes that the package does not name: the unused operation, and pin modes
    // that fall back to floating input.
    localparam logic [2:0] OP_UNUSED      = 3'd7;
    localparam logic [2:0] PM_RESERVED_LO = 3'd6;
    localparam logic [2:0] PM_RESERVED_HI = 3'd7;

    localparam logic [FIELD_W-1:0] SPAN_MASK = {FIELD_W{1'b1}} >> (FIELD_W - PIN_SPAN);
    localparam logic [FIELD_W-1:0] ALL_PINS  = {FIELD_W{1'b1}};
    localparam logic [FIELD_W-1:0] NO_PINS   = '0;

    localparam int RANDOM_WORDS = 450;
    localparam int MAX_GAP      = 18;
    // The drain at the end leaves room for stray results from the block.
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   word_bus = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // Words waiting to be sent, and the results that accepted words must give.
    t_item   port_word_q[$];
    t_result expected_port_q[$];

    // The predictor's copy of the port state.
    logic                 port_en   [NUM_PORTS];
    logic [MODE_W-1:0]    pin_cfg   [NUM_PORTS];
    logic [FIELD_W-1:0]   drive_regs[NUM_PORTS];

    int gap_left;
    int calm_left;
    int fail_count;
    int cycle_count;

    gpio_port_register_block_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (word_bus),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    // Configuration nibble that a pin mode and pull choice select.
    function automatic logic [3:0] nibble_for_mode(input logic [2:0] mode, input logic pull);
        case (mode)
            PM_INPUT:     return pull ? MC_PULLED : MC_FLOATING;
            PM_PUSH_PULL: return MC_PUSH_PULL;
            PM_OPEN_DRN:  return MC_OPEN_DRN;
            PM_ANALOG:    return MC_ANALOG;
            PM_ALT_PP:    return MC_ALT_PP;
            PM_ALT_OD:    return MC_ALT_OD;
            default:      return MC_FLOATING;
        endcase
    endfunction

    // Applies one accepted word to the port state and queues the result it gives.
    task automatic apply_port_word(input t_item w);
        t_result            r;
        logic [FIELD_W-1:0] mask;
        logic [3:0]         nib;
        int                 p;
        r    = '0;
        p    = w.port_index;
        mask = w.pin_mask & SPAN_MASK;
        // A port beyond the last one changes nothing and answers with zeros.
        if (p < NUM_PORTS) begin
            case (w.operation)
                OP_ENABLE: port_en[p] = 1'b1;
                OP_CONFIGURE: begin
                    nib = nibble_for_mode(w.pin_mode, w.pull_enable);
                    for (int i = 0; i < PIN_SPAN; i++) begin
                        if (mask[i]) begin
                            pin_cfg[p][4*i +: 4] = nib;
                        end
                    end
                end
                OP_WRITE:  drive_regs[p] = (drive_regs[p] & ~mask) | (w.level_bits & mask);
                OP_SET:    drive_regs[p] = drive_regs[p] | mask;
                OP_CLEAR:  drive_regs[p] = drive_regs[p] & ~mask;
                OP_TOGGLE: drive_regs[p] = drive_regs[p] ^ mask;
                OP_READ:   r.read_data = w.pin_levels_in & mask;
                default: ;
            endcase
            drive_regs[p]   = drive_regs[p] & SPAN_MASK;
            r.output_levels = drive_regs[p];
            r.port_enabled  = port_en[p];
        end
        expected_port_q.push_back(r);
    endtask

    task automatic add_word(input logic [2:0] op, input logic [2:0] port,
                            input logic [FIELD_W-1:0] mask, input logic [FIELD_W-1:0] level,
                            input logic [2:0] mode, input logic pull,
                            input logic [FIELD_W-1:0] pins);
        t_item w;
        w.operation     = op;
        w.port_index    = port;
        w.pin_mask      = mask;
        w.level_bits    = level;
        w.pin_mode      = mode;
        w.pull_enable   = pull;
        w.pin_levels_in = pins;
        port_word_q.push_back(w);
    endtask

    function automatic t_item random_word();
        t_item w;
        w.operation = 3'($urandom_range(0, 6));
        if ($urandom_range(0, 24) == 0) begin
            w.operation = OP_UNUSED;
        end
        w.port_index = 3'($urandom_range(0, NUM_PORTS - 1));
        if ($urandom_range(0, 19) == 0) begin
            w.port_index = 3'($urandom_range(NUM_PORTS, 7));
        end
        case ($urandom_range(0, 5))
            0:       w.pin_mask = ALL_PINS;
            1:       w.pin_mask = NO_PINS;
            2:       w.pin_mask = FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
            default: w.pin_mask = FIELD_W'($urandom);
        endcase
        w.level_bits    = FIELD_W'($urandom);
        w.pin_mode      = 3'($urandom_range(0, 7));
        w.pull_enable   = 1'($urandom_range(0, 1));
        w.pin_levels_in = FIELD_W'($urandom);
        return w;
    endfunction

    // Pause before the next word; now and then a calm stretch sends back to back.
    function automatic int draw_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Driver: a word is taken at an edge where start is high and busy is low.
    always @(posedge clk) begin
        logic  next_start;
        t_item next_word;
        if (!rst_n) begin
            start    <= 1'b0;
            word_bus <= '0;
        end else begin
            next_start = start;
            next_word  = word_bus;
            if (start && !busy) begin
                apply_port_word(word_bus);
                next_start = 1'b0;
            end
            if (!next_start && port_word_q.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    next_word  = port_word_q.pop_front();
                    next_start = 1'b1;
                    gap_left   = draw_gap();
                end
            end
            start    <= next_start;
            word_bus <= next_word;
        end
    end

    // Monitor: each strobed result must match the oldest expected one.
    always @(posedge clk) begin
        t_result want;
        if (rst_n && o_done) begin
            if (expected_port_q.size() == 0) begin
                report_mismatch($sformatf("result %h with no word outstanding", o_result));
            end else begin
                want = expected_port_q.pop_front();
                if (o_result.read_data !== want.read_data) begin
                    report_mismatch($sformatf("read_data %h, wanted %h",
                                              o_result.read_data, want.read_data));
                end
                if (o_result.output_levels !== want.output_levels) begin
                    report_mismatch($sformatf("output_levels %h, wanted %h",
                                              o_result.output_levels, want.output_levels));
                end
                if (o_result.port_enabled !== want.port_enabled) begin
                    report_mismatch($sformatf("port_enabled %b, wanted %b",
                                              o_result.port_enabled, want.port_enabled));
                end
            end
        end
    end

    // Watchdog against a block that stops answering.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        gap_left    = 0;
        calm_left   = 0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            port_en[p]    = 1'b0;
            pin_cfg[p]    = {PIN_SPAN{MC_FLOATING}};
            drive_regs[p] = '0;
        end

        // Directed part. A read straight after reset, then enabling port 0 twice and the last port.
        add_word(OP_READ, 3'd0, ALL_PINS, NO_PINS, PM_INPUT, 1'b0, ALL_PINS);
        add_word(OP_ENABLE, 3'd0, NO_PINS, NO_PINS, PM_INPUT, 1'b0, NO_PINS);
        add_word(OP_ENABLE, 3'd0, ALL_PINS, ALL_PINS, PM_ALT_OD, 1'b1, ALL_PINS);
        add_word(OP_ENABLE, 3'(NUM_PORTS - 1), NO_PINS, NO_PINS, PM_INPUT, 1'b0, NO_PINS);
        // Every pin mode, pulled and floating input, and the fallback modes.
        add_word(OP_CONFIGURE, 3'd0, ALL_PINS, NO_PINS, PM_INPUT, 1'b0, NO_PINS);
        add_word(OP_CONFIGURE, 3'd0, 16'h00FF, NO_PINS, PM_INPUT, 1'b1, NO_PINS);
        add_word(OP_CONFIGURE, 3'd1, 16'hAAAA, NO_PINS, PM_PUSH_PULL, 1'b0, NO_PINS);
        add_word(OP_CONFIGURE, 3'd1, 16'h5555, NO_PINS, PM_OPEN_DRN, 1'b1, NO_PINS);
        add_word(OP_CONFIGURE, 3'd2, ALL_PINS, NO_PINS, PM_ANALOG, 1'b0, NO_PINS);
        add_word(OP_CONFIGURE, 3'd2, 16'h8001, NO_PINS, PM_ALT_PP, 1'b0, NO_PINS);
        add_word(OP_CONFIGURE, 3'd3, ALL_PINS, NO_PINS, PM_ALT_OD, 1'b1, NO_PINS);
        add_word(OP_CONFIGURE, 3'd3, 16'h0F0F, NO_PINS, PM_RESERVED_LO, 1'b1, NO_PINS);
        add_word(OP_CONFIGURE, 3'd3, NO_PINS, NO_PINS, PM_RESERVED_HI, 1'b0, NO_PINS);
        // Output register changes, including an empty mask.
        add_word(OP_WRITE, 3'd1, ALL_PINS, 16'hA5A5, PM_INPUT, 1'b0, NO_PINS);
        add_word(OP_WRITE, 3'd1, NO_PINS, ALL_PINS, PM_INPUT, 1'b0, NO_PINS);
        add_word(OP_WRITE, 3'd1, 16'hFF00, 16'h5A5A, PM_INPUT, 1'b0, NO_PINS);
        add_word(OP_SET, 3'd2, ALL_PINS, NO_PINS, PM_INPUT, 1'b0, NO_PINS);
        add_word(OP_CLEAR, 3'd2, 16'h00FF, ALL_PINS, PM_INPUT, 1'b0, NO_PINS);
        add_word(OP_TOGGLE, 3'd2, ALL_PINS, NO_PINS, PM_INPUT, 1'b0, NO_PINS);
        add_word(OP_TOGGLE, 3'(NUM_PORTS - 1), 16'h8000, NO_PINS, PM_INPUT, 1'b0, NO_PINS);
        // Reads with empty and full masks.
        add_word(OP_READ, 3'd2, NO_PINS, NO_PINS, PM_INPUT, 1'b0, ALL_PINS);
        add_word(OP_READ, 3'd4, ALL_PINS, NO_PINS, PM_INPUT, 1'b0, 16'hC3C3);
        // A port beyond the last one, and the unused operation.
        add_word(OP_WRITE, 3'(NUM_PORTS), ALL_PINS, ALL_PINS, PM_INPUT, 1'b0, ALL_PINS);
        add_word(OP_READ, 3'd7, ALL_PINS, ALL_PINS, PM_INPUT, 1'b0, ALL_PINS);
        add_word(OP_UNUSED, 3'd1, ALL_PINS, ALL_PINS, PM_ALT_OD, 1'b1, ALL_PINS);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            port_word_q.push_back(random_word());
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (port_word_q.size() != 0 || start || expected_port_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_port_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
